// File: hdl/branch_taken_transition_profiler_defines.svh
// Assertion macros shared by the profiler modules.
`ifndef BRANCH_TAKEN_TRANSITION_PROFILER_DEFINES_SVH
`define BRANCH_TAKEN_TRANSITION_PROFILER_DEFINES_SVH

// Condition must hold at every edge outside reset.
`define BTP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent now implies consequent in the next cycle.
`define BTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/btp_pkg.sv
// Shared types, codes and helpers of the branch profiler.
package btp_pkg;

  localparam int unsigned EXEC_W   = 48;
  localparam int unsigned STAT_W   = 11;
  localparam int unsigned PC_W     = 48;
  localparam int unsigned BINSEL_W = 5;

  localparam logic [STAT_W-1:0] STAT_MAX = '1;
  localparam logic [EXEC_W-1:0] EXEC_MAX = '1;

  // Request opcodes
  localparam logic [2:0] OP_RECORD   = 3'd0;
  localparam logic [2:0] OP_FINALIZE = 3'd1;
  localparam logic [2:0] OP_RD_JOINT = 3'd2;
  localparam logic [2:0] OP_RD_TAKEN = 3'd3;
  localparam logic [2:0] OP_RD_FLIP  = 3'd4;

  typedef struct packed {
    logic [2:0]          opcode;
    logic [PC_W-1:0]     branch_pc;
    logic                branch_taken;
    logic [BINSEL_W-1:0] taken_bin;
    logic [BINSEL_W-1:0] transition_bin;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [STAT_W-1:0] static_count;
    logic [EXEC_W-1:0] exec_count;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_REC,
    CMD_FIN,
    CMD_RD_J,
    CMD_RD_T,
    CMD_RD_F,
    CMD_NOP
  } cmd_kind_t;

  // Classified request handed from front to back
  typedef struct packed {
    cmd_kind_t kind;
    logic      in_range;
    in_item_t  item;
  } cmd_t;

  // One histogram bin
  typedef struct packed {
    logic [STAT_W-1:0] stat;
    logic [EXEC_W-1:0] exec;
  } hist_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_ALLOC,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_FIN_RD,
    ST_FIN_MUL,
    ST_FIN_DIV,
    ST_FIN_HRD,
    ST_FIN_HWR,
    ST_OP_RD,
    ST_OP_WAIT,
    ST_DONE
  } state_t;

  function automatic logic [STAT_W-1:0] stat_inc(input logic [STAT_W-1:0] v);
    stat_inc = (v == STAT_MAX) ? v : v + STAT_W'(1);
  endfunction

  function automatic logic [EXEC_W-1:0] exec_add(input logic [EXEC_W-1:0] a,
                                                 input logic [EXEC_W-1:0] b);
    logic [EXEC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    exec_add = s[EXEC_W] ? EXEC_MAX : s[EXEC_W-1:0];
  endfunction

endpackage

// File: hdl/btp_front.sv
// Front end: decodes requests, checks bin ranges and queues them for the back end.
module btp_front #(
  parameter int unsigned RATE_BINS = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  btp_pkg::in_item_t in_item,
  output logic              cmd_valid,
  input  logic              cmd_pop,
  output btp_pkg::cmd_t     cmd
);

  btp_pkg::cmd_t q_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  btp_pkg::cmd_t cls;
  logic          tb_ok;
  logic          fb_ok;
  logic          push_ok;
  logic          pop_ok;

  // Decode opcode and bin ranges
  always_comb begin
    tb_ok        = int'(in_item.taken_bin) < RATE_BINS;
    fb_ok        = int'(in_item.transition_bin) < RATE_BINS;
    cls.item     = in_item;
    cls.in_range = 1'b0;
    unique case (in_item.opcode)
      btp_pkg::OP_RECORD: begin
        cls.kind = btp_pkg::CMD_REC;
      end
      btp_pkg::OP_FINALIZE: begin
        cls.kind = btp_pkg::CMD_FIN;
      end
      btp_pkg::OP_RD_JOINT: begin
        cls.kind     = btp_pkg::CMD_RD_J;
        cls.in_range = tb_ok && fb_ok;
      end
      btp_pkg::OP_RD_TAKEN: begin
        cls.kind     = btp_pkg::CMD_RD_T;
        cls.in_range = tb_ok;
      end
      btp_pkg::OP_RD_FLIP: begin
        cls.kind     = btp_pkg::CMD_RD_F;
        cls.in_range = fb_ok;
      end
      default: begin
        cls.kind = btp_pkg::CMD_NOP;
      end
    endcase
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push_ok   = in_push && !in_full;
  assign pop_ok    = cmd_pop && cmd_valid;

  // Two-entry request queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop_ok) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push_ok) - 2'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// File: hdl/btp_back.sv
// Back end: table lookup and update, histogram rebuild and bin reads.
`include "branch_taken_transition_profiler_defines.svh"
module btp_back #(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned RATE_BINS     = 20,
  parameter int unsigned COUNT_WIDTH   = 32,
  parameter int unsigned ADDR_WIDTH    = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  btp_pkg::cmd_t      cmd,
  output logic               res_valid,
  input  logic               res_ready,
  output btp_pkg::out_item_t res
);

  localparam int unsigned IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned FILL_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned CW      = COUNT_WIDTH;
  localparam int unsigned CNT_W   = 3 * CW + 1;
  localparam int unsigned EW      = CW + 1;
  localparam int unsigned BIN_W   = $clog2(RATE_BINS);
  localparam int unsigned DW      = CW + BIN_W;
  localparam int unsigned KW      = $clog2(BIN_W + 1);
  localparam int unsigned J_DEPTH = RATE_BINS * RATE_BINS;
  localparam int unsigned J_W     = $clog2(J_DEPTH);

  btp_pkg::state_t state_r, state_nxt;

  // Table storage
  logic [ADDR_WIDTH-1:0] addr_mem [TABLE_ENTRIES];
  logic [CNT_W-1:0]      cnt_mem  [TABLE_ENTRIES];
  // Histogram storage
  btp_pkg::hist_word_t   joint_mem [J_DEPTH];
  btp_pkg::hist_word_t   tmarg_mem [RATE_BINS];
  btp_pkg::hist_word_t   fmarg_mem [RATE_BINS];

  logic [ADDR_WIDTH-1:0] addr_rd_r;
  logic [CNT_W-1:0]      cnt_rd_r;
  btp_pkg::hist_word_t   j_rd_r, t_rd_r, f_rd_r;

  logic [FILL_W-1:0]     fill_r;
  logic [IDX_W-1:0]      idx_r;
  logic [IDX_W-1:0]      slot_r;
  logic [J_W-1:0]        clr_r;
  logic                  clr_fin_r;
  logic [btp_pkg::EXEC_W-1:0] gt_r;
  btp_pkg::cmd_t         cur_r;
  btp_pkg::out_item_t    res_r;

  logic [EW-1:0]         e_r;
  logic [DW-1:0]         tp_r, fp_r;
  logic                  tge_r, fge_r;
  logic [KW-1:0]         k_r;
  logic [BIN_W-1:0]      tq_r, fq_r;
  logic [BIN_W-1:0]      tb_r, fb_r;
  logic [J_W-1:0]        j_r;

  // Combinational helpers
  logic [ADDR_WIDTH-1:0] key;
  logic                  last_idx;
  logic                  clr_last;
  logic                  match;
  logic                  full;
  logic [CW-1:0]         c_t, c_n, c_f;
  logic                  c_last;
  logic [EW-1:0]         sum_e;
  logic [DW-1:0]         trial;
  logic                  t_step, f_step;
  logic [BIN_W-1:0]      tb_c, fb_c;
  logic [J_W-1:0]        j_c;
  logic [BIN_W-1:0]      rd_tb, rd_fb;
  logic [J_W-1:0]        rd_j;
  logic [btp_pkg::EXEC_W-1:0] e48;

  // Memory controls
  logic                  addr_we;
  logic                  cnt_we;
  logic [IDX_W-1:0]      cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]      cnt_wdata;
  logic                  j_we, t_we, f_we;
  logic [J_W-1:0]        j_waddr, j_raddr;
  logic [BIN_W-1:0]      t_waddr, t_raddr, f_waddr, f_raddr;
  btp_pkg::hist_word_t   j_wdata, t_wdata, f_wdata;

  function automatic logic [CW-1:0] cnt_inc(input logic [CW-1:0] v);
    cnt_inc = (&v) ? v : v + CW'(1);
  endfunction

  // Datapath helpers
  always_comb begin
    key      = ADDR_WIDTH'(cur_r.item.branch_pc);
    last_idx = (FILL_W'(idx_r) + FILL_W'(1)) == fill_r;
    clr_last = (clr_r == J_W'(J_DEPTH - 1));
    match    = (addr_rd_r == key);
    full     = (fill_r == FILL_W'(TABLE_ENTRIES));
    c_last   = cnt_rd_r[CNT_W-1];
    c_t      = cnt_rd_r[3*CW-1:2*CW];
    c_n      = cnt_rd_r[2*CW-1:CW];
    c_f      = cnt_rd_r[CW-1:0];
    sum_e    = EW'(c_t) + EW'(c_n);
    trial    = DW'(e_r) << k_r;
    t_step   = (tp_r >= trial);
    f_step   = (fp_r >= trial);
    e48      = btp_pkg::EXEC_W'(e_r);
    // Bin selection: zero total goes to bin 0, part >= total to the top bin
    if (e_r == '0) begin
      tb_c = '0;
      fb_c = '0;
    end else begin
      tb_c = tge_r ? BIN_W'(RATE_BINS - 1) : tq_r;
      fb_c = fge_r ? BIN_W'(RATE_BINS - 1) : fq_r;
    end
    j_c   = J_W'(fb_c) * J_W'(RATE_BINS) + J_W'(tb_c);
    rd_tb = BIN_W'(cur_r.item.taken_bin);
    rd_fb = BIN_W'(cur_r.item.transition_bin);
    rd_j  = J_W'(rd_fb) * J_W'(RATE_BINS) + J_W'(rd_tb);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      btp_pkg::ST_CLEAR: begin
        if (clr_last) begin
          if (!clr_fin_r) begin
            state_nxt = btp_pkg::ST_IDLE;
          end else if (fill_r == '0) begin
            state_nxt = btp_pkg::ST_DONE;
          end else begin
            state_nxt = btp_pkg::ST_FIN_RD;
          end
        end
      end
      btp_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind) inside
            btp_pkg::CMD_REC: begin
              state_nxt = (fill_r == '0) ? btp_pkg::ST_ALLOC : btp_pkg::ST_SCAN_RD;
            end
            btp_pkg::CMD_FIN: begin
              state_nxt = btp_pkg::ST_CLEAR;
            end
            btp_pkg::CMD_RD_J, btp_pkg::CMD_RD_T, btp_pkg::CMD_RD_F: begin
              state_nxt = cmd.in_range ? btp_pkg::ST_OP_RD : btp_pkg::ST_DONE;
            end
            default: begin
              state_nxt = btp_pkg::ST_DONE;
            end
          endcase
        end
      end
      btp_pkg::ST_SCAN_RD:  state_nxt = btp_pkg::ST_SCAN_CMP;
      btp_pkg::ST_SCAN_CMP: begin
        if (match) begin
          state_nxt = btp_pkg::ST_CNT_RD;
        end else if (last_idx) begin
          state_nxt = btp_pkg::ST_ALLOC;
        end else begin
          state_nxt = btp_pkg::ST_SCAN_RD;
        end
      end
      btp_pkg::ST_ALLOC:    state_nxt = btp_pkg::ST_DONE;
      btp_pkg::ST_CNT_RD:   state_nxt = btp_pkg::ST_CNT_WR;
      btp_pkg::ST_CNT_WR:   state_nxt = btp_pkg::ST_DONE;
      btp_pkg::ST_FIN_RD:   state_nxt = btp_pkg::ST_FIN_MUL;
      btp_pkg::ST_FIN_MUL:  state_nxt = btp_pkg::ST_FIN_DIV;
      btp_pkg::ST_FIN_DIV: begin
        if (k_r == '0) begin
          state_nxt = btp_pkg::ST_FIN_HRD;
        end
      end
      btp_pkg::ST_FIN_HRD:  state_nxt = btp_pkg::ST_FIN_HWR;
      btp_pkg::ST_FIN_HWR: begin
        state_nxt = last_idx ? btp_pkg::ST_DONE : btp_pkg::ST_FIN_RD;
      end
      btp_pkg::ST_OP_RD:    state_nxt = btp_pkg::ST_OP_WAIT;
      btp_pkg::ST_OP_WAIT:  state_nxt = btp_pkg::ST_DONE;
      btp_pkg::ST_DONE: begin
        if (res_ready) begin
          state_nxt = btp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = btp_pkg::ST_IDLE;
    endcase
  end

  // State outputs: handshakes and memory port controls
  always_comb begin
    cmd_pop   = (state_r == btp_pkg::ST_IDLE);
    res_valid = (state_r == btp_pkg::ST_DONE);
    addr_we   = 1'b0;
    cnt_we    = 1'b0;
    cnt_waddr = slot_r;
    cnt_raddr = idx_r;
    cnt_wdata = '0;
    j_we      = 1'b0;
    t_we      = 1'b0;
    f_we      = 1'b0;
    j_waddr   = j_r;
    t_waddr   = tb_r;
    f_waddr   = fb_r;
    j_raddr   = j_c;
    t_raddr   = tb_c;
    f_raddr   = fb_c;
    j_wdata   = '0;
    t_wdata   = '0;
    f_wdata   = '0;
    unique case (state_r)
      btp_pkg::ST_CLEAR: begin
        j_we    = 1'b1;
        t_we    = int'(clr_r) < RATE_BINS;
        f_we    = int'(clr_r) < RATE_BINS;
        j_waddr = clr_r;
        t_waddr = BIN_W'(clr_r);
        f_waddr = BIN_W'(clr_r);
      end
      btp_pkg::ST_ALLOC: begin
        // New branch: first outcome counted, no transition
        addr_we   = !full;
        cnt_we    = !full;
        cnt_waddr = IDX_W'(fill_r);
        cnt_wdata = {cur_r.item.branch_taken, CW'(cur_r.item.branch_taken),
                     CW'(!cur_r.item.branch_taken), CW'(0)};
      end
      btp_pkg::ST_CNT_RD: begin
        cnt_raddr = slot_r;
      end
      btp_pkg::ST_CNT_WR: begin
        cnt_we    = 1'b1;
        cnt_wdata = {cur_r.item.branch_taken,
                     cur_r.item.branch_taken ? cnt_inc(c_t) : c_t,
                     cur_r.item.branch_taken ? c_n : cnt_inc(c_n),
                     (c_last != cur_r.item.branch_taken) ? cnt_inc(c_f) : c_f};
      end
      btp_pkg::ST_FIN_HWR: begin
        j_we    = 1'b1;
        t_we    = 1'b1;
        f_we    = 1'b1;
        j_wdata = '{stat: btp_pkg::stat_inc(j_rd_r.stat),
                    exec: btp_pkg::exec_add(j_rd_r.exec, e48)};
        t_wdata = '{stat: btp_pkg::stat_inc(t_rd_r.stat),
                    exec: btp_pkg::exec_add(t_rd_r.exec, e48)};
        f_wdata = '{stat: btp_pkg::stat_inc(f_rd_r.stat),
                    exec: btp_pkg::exec_add(f_rd_r.exec, e48)};
      end
      btp_pkg::ST_OP_RD: begin
        j_raddr = rd_j;
        t_raddr = rd_tb;
        f_raddr = rd_fb;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= btp_pkg::ST_CLEAR;
      fill_r    <= '0;
      clr_r     <= '0;
      clr_fin_r <= 1'b0;
      gt_r      <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        btp_pkg::ST_IDLE: begin
          clr_r <= '0;
          if (cmd_valid && cmd.kind == btp_pkg::CMD_FIN) begin
            clr_fin_r <= 1'b1;
            gt_r      <= '0;
          end
        end
        btp_pkg::ST_CLEAR: begin
          clr_r <= clr_r + J_W'(1);
        end
        btp_pkg::ST_ALLOC: begin
          if (!full) begin
            fill_r <= fill_r + FILL_W'(1);
          end
        end
        btp_pkg::ST_FIN_HWR: begin
          gt_r <= btp_pkg::exec_add(gt_r, e48);
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      btp_pkg::ST_IDLE: begin
        cur_r <= cmd;
        idx_r <= '0;
        res_r <= '0;
      end
      btp_pkg::ST_SCAN_CMP: begin
        slot_r <= idx_r;
        if (!match && !last_idx) begin
          idx_r <= idx_r + IDX_W'(1);
        end
      end
      btp_pkg::ST_ALLOC: begin
        res_r.status <= full;
      end
      btp_pkg::ST_FIN_MUL: begin
        e_r   <= sum_e;
        tp_r  <= DW'(c_t) * DW'(RATE_BINS);
        fp_r  <= DW'(c_f) * DW'(RATE_BINS);
        tge_r <= EW'(c_t) >= sum_e;
        fge_r <= EW'(c_f) >= sum_e;
        k_r   <= KW'(BIN_W - 1);
        tq_r  <= '0;
        fq_r  <= '0;
      end
      btp_pkg::ST_FIN_DIV: begin
        // One quotient bit per cycle, restoring
        if (t_step) begin
          tp_r <= tp_r - trial;
        end
        if (f_step) begin
          fp_r <= fp_r - trial;
        end
        tq_r <= (tq_r << 1) | BIN_W'(t_step);
        fq_r <= (fq_r << 1) | BIN_W'(f_step);
        k_r  <= k_r - KW'(1);
      end
      btp_pkg::ST_FIN_HRD: begin
        tb_r <= tb_c;
        fb_r <= fb_c;
        j_r  <= j_c;
      end
      btp_pkg::ST_FIN_HWR: begin
        idx_r            <= idx_r + IDX_W'(1);
        res_r.exec_count <= btp_pkg::exec_add(gt_r, e48);
      end
      btp_pkg::ST_OP_WAIT: begin
        case (cur_r.kind)
          btp_pkg::CMD_RD_J: begin
            res_r.static_count <= j_rd_r.stat;
            res_r.exec_count   <= j_rd_r.exec;
          end
          btp_pkg::CMD_RD_T: begin
            res_r.static_count <= t_rd_r.stat;
            res_r.exec_count   <= t_rd_r.exec;
          end
          default: begin
            res_r.static_count <= f_rd_r.stat;
            res_r.exec_count   <= f_rd_r.exec;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Table memories
  always_ff @(posedge clk) begin
    if (addr_we) begin
      addr_mem[IDX_W'(fill_r)] <= key;
    end
    addr_rd_r <= addr_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd_r <= cnt_mem[cnt_raddr];
  end

  // Histogram memories
  always_ff @(posedge clk) begin
    if (j_we) begin
      joint_mem[j_waddr] <= j_wdata;
    end
    j_rd_r <= joint_mem[j_raddr];
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tmarg_mem[t_waddr] <= t_wdata;
    end
    t_rd_r <= tmarg_mem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      fmarg_mem[f_waddr] <= f_wdata;
    end
    f_rd_r <= fmarg_mem[f_raddr];
  end

  assign res = res_r;

  `BTP_ASSERT_ALWAYS(a_fill_bound, fill_r <= FILL_W'(TABLE_ENTRIES), "table fill count overran")
  `BTP_ASSERT_NEXT(a_fill_alloc_only, state_r != btp_pkg::ST_ALLOC, $stable(fill_r), "fill changed outside allocation")
  `BTP_ASSERT_NEXT(a_result_held, state_r == btp_pkg::ST_DONE && !res_ready, state_r == btp_pkg::ST_DONE && $stable(res_r), "result dropped while stalled")

endmodule

// File: hdl/branch_taken_transition_profiler.sv
// Record: scans the table entry by entry, then counts the outcome in the matching
// entry, or allocates a new one if none matches, and returns the result.
// Finalize: clears the histograms, then for each valid entry works out its bins with
// a restoring divider and adds it to them. One request is worked at a time.
// Reset is synchronous, active low; afterwards the block clears its histograms
// before it takes a request.
`include "branch_taken_transition_profiler_defines.svh"
module branch_taken_transition_profiler #(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned RATE_BINS     = 20,
  parameter int unsigned COUNT_WIDTH   = 32,
  parameter int unsigned ADDR_WIDTH    = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  btp_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output btp_pkg::out_item_t out_item
);

  logic               cmd_valid;
  logic               cmd_pop;
  btp_pkg::cmd_t      cmd;
  logic               res_valid;
  logic               res_ready;
  btp_pkg::out_item_t res;
  logic               out_valid_r;
  btp_pkg::out_item_t out_item_r;

  btp_front #(
    .RATE_BINS (RATE_BINS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  btp_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .RATE_BINS     (RATE_BINS),
    .COUNT_WIDTH   (COUNT_WIDTH),
    .ADDR_WIDTH    (ADDR_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register
  assign res_ready = !out_valid_r || out_pop;
  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_item_r <= res;
    end
  end

  `BTP_ASSERT_NEXT(a_out_kept, out_valid_r && !out_pop, out_valid_r && $stable(out_item_r), "waiting result lost")

endmodule
